FILE: src/vertex_edge_table_macros.svh
// Assertion macros shared by the vertex/edge table RTL.
`ifndef VERTEX_EDGE_TABLE_MACROS_SVH
`define VERTEX_EDGE_TABLE_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define VET_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define VET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/vet_pkg.sv
// Shared types and constants for the vertex/edge table.
`timescale 1ns / 1ps

package vet_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 16;
  localparam int unsigned KEY_W            = 32;
  localparam int unsigned HELD_W           = 5;

  typedef enum logic [1:0] {
    OP_ADD_VERTEX = 2'd0,
    OP_ADD_EDGE   = 2'd1,
    OP_DEL_EDGE   = 2'd2,
    OP_QUERY_EDGE = 2'd3
  } vet_op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_NO_ORIGIN = 3'd3,
    ST_NO_DEST   = 3'd4,
    ST_REPEATED  = 3'd5,
    ST_PRESENT   = 3'd6,
    ST_ABSENT    = 3'd7
  } vet_status_t;

  // Lookup request walking down the cell chain
  typedef struct packed {
    logic              active;
    logic [KEY_W-1:0]  first_key;
    logic [KEY_W-1:0]  second_key;
    logic              org_hit;
    logic              dst_hit;
  } vet_probe_t;

endpackage

FILE: src/vertex_edge_table.sv
// Top level of the vertex/edge table: cell chain plus operation control.
`timescale 1ns / 1ps
`include "vertex_edge_table_macros.svh"

// The row of vertex cells sets the timing of every operation. The lookup
// walks the cells one cell per cycle, through a register in each cell.
// The result strobe is registered when the lookup leaves the last cell,
// and the table is updated on the edge that raises it. busy is high
// from the accepted start until the strobe rises. out_valid is high for
// exactly one cycle and the receiver cannot stall it, so capture the
// result in that cycle. A new start is taken in the same cycle as the
// strobe, not before. No clearing pass is needed after reset.
module vertex_edge_table import vet_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_operation,
  input  logic [KEY_W-1:0]  in_first_key,
  input  logic [KEY_W-1:0]  in_second_key,
  output logic              out_valid,
  output logic [2:0]        out_status,
  output logic [HELD_W-1:0] out_vertices_held
);

  localparam int unsigned N  = MAX_VERTICES;
  localparam int unsigned IW = $clog2(N);
  localparam int unsigned CW = $clog2(N + 1);

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_t;

  state_t              state_r;
  vet_op_t             op_r;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       count_nxt;
  logic                out_valid_r;
  vet_status_t         status_r;
  vet_status_t         status_nxt;
  logic [HELD_W-1:0]   held_r;
  logic                accept;

  vet_probe_t          probe_c   [0:N];
  logic [IW-1:0]       org_idx_c [0:N];
  logic [IW-1:0]       dst_idx_c [0:N];
  logic [N-1:0]        org_row_c [0:N];
  logic [N-1:0]        occupied;

  logic                key_we;
  logic [N-1:0]        row_we;
  logic [N-1:0]        row_new;
  logic                present;
  logic                done;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r == S_SEARCH);
  assign done   = (state_r == S_SEARCH) && probe_c[N].active;

  // Inject a new request at the head of the chain
  always_comb begin
    probe_c[0].active     = accept;
    probe_c[0].first_key  = in_first_key;
    probe_c[0].second_key = in_second_key;
    probe_c[0].org_hit    = 1'b0;
    probe_c[0].dst_hit    = 1'b0;
    org_idx_c[0]          = '0;
    dst_idx_c[0]          = '0;
    org_row_c[0]          = '0;
  end

  // Build the row of vertex cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    assign occupied[i] = (CW'(i) < count_r);

    vet_cell #(
      .N   (N),
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .occupied  (occupied[i]),
      .key_we    (key_we && (count_r[IW-1:0] == IW'(i))),
      .key_wdata (probe_c[N].first_key),
      .row_we    (row_we[i]),
      .row_wdata (row_new),
      .probe_i   (probe_c[i]),
      .org_idx_i (org_idx_c[i]),
      .dst_idx_i (dst_idx_c[i]),
      .org_row_i (org_row_c[i]),
      .probe_o   (probe_c[i+1]),
      .org_idx_o (org_idx_c[i+1]),
      .dst_idx_o (dst_idx_c[i+1]),
      .org_row_o (org_row_c[i+1])
    );
  end

  // Decide status and table updates when the lookup leaves the chain
  always_comb begin
    status_nxt = ST_OK;
    count_nxt  = count_r;
    key_we     = 1'b0;
    row_we     = '0;
    row_new    = org_row_c[N];
    present    = org_row_c[N][dst_idx_c[N]];
    unique case (op_r)
      OP_ADD_VERTEX: begin
        if (count_r >= CW'(N)) begin
          status_nxt = ST_FULL;
        end else if (probe_c[N].org_hit) begin
          status_nxt = ST_DUPLICATE;
        end else begin
          key_we    = done;
          count_nxt = count_r + CW'(1);
        end
      end
      default: begin
        if (!probe_c[N].org_hit) begin
          status_nxt = ST_NO_ORIGIN;
        end else if (!probe_c[N].dst_hit) begin
          status_nxt = ST_NO_DEST;
        end else if (op_r == OP_ADD_EDGE) begin
          if (present) begin
            status_nxt = ST_REPEATED;
          end else begin
            row_new[dst_idx_c[N]]   = 1'b1;
            row_we[org_idx_c[N]]    = done;
          end
        end else if (op_r == OP_DEL_EDGE) begin
          if (!present) begin
            status_nxt = ST_ABSENT;
          end else begin
            row_new[dst_idx_c[N]]   = 1'b0;
            row_we[org_idx_c[N]]    = done;
          end
        end else begin
          status_nxt = present ? ST_PRESENT : ST_ABSENT;
        end
      end
    endcase
  end

  // Sequence one request and register the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_SEARCH;
            op_r    <= vet_op_t'(in_operation);
          end
        end
        S_SEARCH: begin
          if (probe_c[N].active) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
            status_r    <= status_nxt;
            held_r      <= HELD_W'(count_nxt);
            count_r     <= count_nxt;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_vertices_held = held_r;

  // Checks
  `VET_ASSERT_NEXT(a_accept_busy, accept, busy, "busy not raised after start")
  `VET_ASSERT_SAME(a_result_idle, out_valid, !busy, "result shown while busy")
  `VET_ASSERT_NEXT(a_done_result, done, out_valid, "lookup finished without result")
  `VET_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe repeated")
  `VET_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CW'(N), "vertex count overflow")

endmodule

FILE: src/vet_cell.sv
// One vertex slot: key, adjacency row, and one stage of the lookup chain.
`timescale 1ns / 1ps

module vet_cell import vet_pkg::*; #(
  parameter int unsigned N   = MAX_VERTICES_DEF,
  parameter int unsigned IDX = 0,
  localparam int unsigned IW = $clog2(N)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             occupied,
  input  logic             key_we,
  input  logic [KEY_W-1:0] key_wdata,
  input  logic             row_we,
  input  logic [N-1:0]     row_wdata,
  input  vet_probe_t       probe_i,
  input  logic [IW-1:0]    org_idx_i,
  input  logic [IW-1:0]    dst_idx_i,
  input  logic [N-1:0]     org_row_i,
  output vet_probe_t       probe_o,
  output logic [IW-1:0]    org_idx_o,
  output logic [IW-1:0]    dst_idx_o,
  output logic [N-1:0]     org_row_o
);

  logic [KEY_W-1:0] key_r;
  logic [N-1:0]     row_r;
  vet_probe_t       probe_r;
  logic [IW-1:0]    org_idx_r;
  logic [IW-1:0]    dst_idx_r;
  logic [N-1:0]     org_row_r;
  logic             org_match;
  logic             dst_match;

  // Compare the passing request against this slot
  assign org_match = occupied && (key_r == probe_i.first_key);
  assign dst_match = occupied && (key_r == probe_i.second_key);

  // Store key on write
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_r <= key_wdata;
    end
  end

  // Hold adjacency row, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else if (row_we) begin
      row_r <= row_wdata;
    end
  end

  // Advance the request to the next cell, merging any hit here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.active <= 1'b0;
    end else begin
      probe_r.active <= probe_i.active;
    end
    probe_r.first_key  <= probe_i.first_key;
    probe_r.second_key <= probe_i.second_key;
    probe_r.org_hit    <= probe_i.org_hit | org_match;
    probe_r.dst_hit    <= probe_i.dst_hit | dst_match;
    org_idx_r          <= org_match ? IW'(IDX) : org_idx_i;
    org_row_r          <= org_match ? row_r : org_row_i;
    dst_idx_r          <= dst_match ? IW'(IDX) : dst_idx_i;
  end

  assign probe_o   = probe_r;
  assign org_idx_o = org_idx_r;
  assign dst_idx_o = dst_idx_r;
  assign org_row_o = org_row_r;

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the vertex/edge table: directed and random graph requests against a predictor.
`timescale 1ns / 1ps

module tb_top;
  import vet_pkg::*;

  localparam int unsigned MAX_V       = MAX_VERTICES_DEF;
  localparam int unsigned LATENCY     = MAX_V + 1;
  localparam int unsigned QUIET_LIMIT = 500;
  localparam int unsigned RANDOM_REQS = 1730;
  localparam int unsigned POOL_SIZE   = 24;

  typedef struct {
    vet_status_t       status;
    logic [HELD_W-1:0] held;
  } graph_status_t;

  // Graph predictor plus the queue of statuses still owed by the block
  class graph_status_board;
    logic [KEY_W-1:0] keys [MAX_V];
    logic [MAX_V-1:0] rows [MAX_V];
    int unsigned      held;
    graph_status_t    status_due [$];
    int unsigned      errors;

    function new();
      held   = 0;
      errors = 0;
      foreach (keys[i]) keys[i] = '0;
      foreach (rows[i]) rows[i] = '0;
    endfunction

    // Look up a key among the held vertices only
    function int find_slot(logic [KEY_W-1:0] key);
      for (int i = 0; i < held; i++) begin
        if (keys[i] == key) return i;
      end
      return -1;
    endfunction

    // Predict the status of an accepted request and update the graph
    function void note_request(vet_op_t op, logic [KEY_W-1:0] k1, logic [KEY_W-1:0] k2);
      graph_status_t res;
      int            org;
      int            dst;
      logic          hit;
      if (op == OP_ADD_VERTEX) begin
        if (held >= MAX_V) begin
          res.status = ST_FULL;
        end else if (find_slot(k1) >= 0) begin
          res.status = ST_DUPLICATE;
        end else begin
          keys[held] = k1;
          held++;
          res.status = ST_OK;
        end
      end else begin
        org = find_slot(k1);
        dst = find_slot(k2);
        if (org < 0) begin
          res.status = ST_NO_ORIGIN;
        end else if (dst < 0) begin
          res.status = ST_NO_DEST;
        end else begin
          hit = rows[org][dst];
          case (op)
            OP_ADD_EDGE: begin
              if (hit) begin
                res.status = ST_REPEATED;
              end else begin
                rows[org][dst] = 1'b1;
                res.status = ST_OK;
              end
            end
            OP_DEL_EDGE: begin
              if (!hit) begin
                res.status = ST_ABSENT;
              end else begin
                rows[org][dst] = 1'b0;
                res.status = ST_OK;
              end
            end
            default: res.status = hit ? ST_PRESENT : ST_ABSENT;
          endcase
        end
      end
      res.held = held[HELD_W-1:0];
      status_due.push_back(res);
    endfunction

    // Compare one strobed result with the oldest prediction
    function void check_result(logic [2:0] status, logic [HELD_W-1:0] cnt);
      graph_status_t exp_res;
      if (status_due.size() == 0) begin
        $display("%0t: unexpected result status=%0d held=%0d", $time, status, cnt);
        errors++;
        return;
      end
      exp_res = status_due.pop_front();
      if (status != exp_res.status) begin
        $display("%0t: status mismatch expected=%0d (%s) actual=%0d", $time,
                 exp_res.status, exp_res.status.name(), status);
        errors++;
      end
      if (cnt != exp_res.held) begin
        $display("%0t: vertices_held mismatch expected=%0d actual=%0d", $time,
                 exp_res.held, cnt);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  vet_op_t           in_operation = OP_ADD_VERTEX;
  logic [KEY_W-1:0]  in_first_key = '0;
  logic [KEY_W-1:0]  in_second_key = '0;
  logic              out_valid;
  logic [2:0]        out_status;
  logic [HELD_W-1:0] out_vertices_held;

  graph_status_board sb = new();
  logic [KEY_W-1:0]  key_pool [POOL_SIZE];
  int unsigned       quiet_cycles = 0;

  vertex_edge_table #(
    .MAX_VERTICES(MAX_V)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_first_key     (in_first_key),
    .in_second_key    (in_second_key),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_vertices_held(out_vertices_held)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Check results before noting a request taken on the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_status, out_vertices_held);
      if (start && !busy) sb.note_request(in_operation, in_first_key, in_second_key);
      if (out_valid || (start && !busy)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[vertex_edge_table] ERROR");
        $finish;
      end
    end
  end

  // Present one request and hold it until the block takes it
  task automatic send_request(vet_op_t op, logic [KEY_W-1:0] k1, logic [KEY_W-1:0] k2);
    start         <= 1'b1;
    in_operation  <= op;
    in_first_key  <= k1;
    in_second_key <= k2;
    do @(posedge clk); while (busy);
  endtask

  // Drop start for a number of cycles, with junk on the fields
  task automatic pause_requests(int unsigned n);
    if (n > 0) begin
      start         <= 1'b0;
      in_operation  <= vet_op_t'($urandom_range(0, 3));
      in_first_key  <= $urandom;
      in_second_key <= $urandom;
      repeat (n) @(posedge clk);
    end
  endtask

  // Pick a key: mostly held vertices, some pool keys, some fully random
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70 && sb.held > 0) return sb.keys[$urandom_range(0, sb.held - 1)];
    if (r < 88) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  task automatic run_directed();
    logic [KEY_W-1:0] kmin;
    logic [KEY_W-1:0] kmax;
    kmin = 32'h8000_0000;
    kmax = 32'h7FFF_FFFF;
    // Edge request on an empty table
    send_request(OP_QUERY_EDGE, kmin, kmax);
    send_request(OP_ADD_VERTEX, kmin, 32'hFFFF_FFFF);
    send_request(OP_ADD_VERTEX, kmax, 32'h0);
    send_request(OP_ADD_VERTEX, kmin, kmax);
    send_request(OP_ADD_EDGE, kmin, kmax);
    send_request(OP_ADD_EDGE, kmin, kmax);
    pause_requests(3);
    send_request(OP_QUERY_EDGE, kmin, kmax);
    send_request(OP_QUERY_EDGE, kmax, kmin);
    send_request(OP_DEL_EDGE, kmax, kmin);
    send_request(OP_DEL_EDGE, kmin, kmax);
    send_request(OP_QUERY_EDGE, kmin, kmax);
    // Unknown origin wins over unknown destination
    send_request(OP_ADD_EDGE, 32'h0, 32'h1);
    send_request(OP_DEL_EDGE, kmin, 32'h0);
    // Self loop
    send_request(OP_ADD_EDGE, kmax, kmax);
    send_request(OP_QUERY_EDGE, kmax, kmax);
    pause_requests(20);
    send_request(OP_ADD_VERTEX, 32'hFFFF_FFFF, 32'h1234_5678);
    send_request(OP_ADD_VERTEX, 32'h0, 32'hFFFF_FFFF);
    // Keys one bit apart are distinct vertices
    send_request(OP_ADD_VERTEX, 32'h0000_0001, 32'h0);
    send_request(OP_QUERY_EDGE, 32'h0000_0001, 32'h0);
    send_request(OP_ADD_EDGE, 32'hFFFF_FFFF, 32'h0000_0001);
    send_request(OP_QUERY_EDGE, 32'hFFFF_FFFE, 32'h0000_0001);
  endtask

  task automatic run_random();
    int unsigned sent;
    int unsigned burst;
    int unsigned r;
    vet_op_t     op;
    sent = 0;
    while (sent < RANDOM_REQS) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        r = $urandom_range(0, 99);
        if (r < 12) op = OP_ADD_VERTEX;
        else if (r < 42) op = OP_ADD_EDGE;
        else if (r < 70) op = OP_DEL_EDGE;
        else op = OP_QUERY_EDGE;
        send_request(op, pick_key(), pick_key());
        sent++;
      end
      // Leave some bursts back to back, space the others
      if ($urandom_range(0, 3) != 0) pause_requests($urandom_range(1, 30));
    end
  endtask

  initial begin
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) begin
      key_pool[i] = (i % 3 == 0) ? (key_pool[i-1] ^ (32'h1 << $urandom_range(0, 31)))
                                 : $urandom;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random();
    pause_requests(1);
    // Drain outstanding results, then watch for strays
    while (sb.status_due.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (sb.errors == 0 && sb.status_due.size() == 0) begin
      $display("[vertex_edge_table] OK");
    end else begin
      $display("[vertex_edge_table] ERROR");
    end
    $finish;
  end

endmodule
